FILE: design/pcm_pkg.sv
// Shared types, constants and the sequencer program of the corridor merge block.
`timescale 1ns / 1ps

package pcm_pkg;

  localparam int unsigned CorridorDepth = 64;
  localparam int unsigned VisitedDepth  = 16;

  localparam int unsigned CorAddrW = $clog2(CorridorDepth);
  localparam int unsigned CorCntW  = $clog2(CorridorDepth + 1);
  localparam int unsigned VisAddrW = (VisitedDepth > 1) ? $clog2(VisitedDepth) : 1;
  localparam int unsigned VisCntW  = $clog2(VisitedDepth + 1);
  localparam int unsigned SumW     = CorCntW + 1;

  localparam int unsigned IdW     = 32;
  localparam int unsigned PosW    = 6;
  localparam int unsigned LenW    = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned StepW   = 5;

  typedef enum logic [1:0] {
    CmdCorAppend = 2'd0,
    CmdVisAppend = 2'd1,
    CmdMerge     = 2'd2,
    CmdClear     = 2'd3
  } cmd_e;

  localparam logic [StatusW-1:0] StMerged = 2'd0;
  localparam logic [StatusW-1:0] StNoHit  = 2'd1;
  localparam logic [StatusW-1:0] StEmpty  = 2'd2;

  typedef struct packed {
    cmd_e             command;
    logic [IdW-1:0]   poly_id;
  } in_t;

  typedef struct packed {
    logic [IdW-1:0]     poly_id_res;
    logic [PosW-1:0]    position;
    logic               last;
    logic [LenW-1:0]    new_length;
    logic [StatusW-1:0] status;
    logic               overflow;
  } out_t;

  // Datapath operations, one per microcode step.
  typedef enum logic [3:0] {
    OpNone,
    OpAccept,
    OpInit,
    OpSRead,
    OpAdvance,
    OpHitSet,
    OpBRead,
    OpBWrite,
    OpFlip,
    OpNoHit,
    OpESet,
    OpERead,
    OpEmit,
    OpZEmit
  } op_e;

  typedef enum logic [2:0] {
    CondAlways,
    CondMerge,
    CondCorEmpty,
    CondVisEmpty,
    CondMatch,
    CondSearchDone,
    CondKLast,
    CondOutFree
  } cond_e;

  localparam logic [StepW-1:0] StepIdle   = 5'd0;
  localparam logic [StepW-1:0] StepInit   = 5'd1;
  localparam logic [StepW-1:0] StepVChk   = 5'd2;
  localparam logic [StepW-1:0] StepSRead  = 5'd3;
  localparam logic [StepW-1:0] StepSCmp   = 5'd4;
  localparam logic [StepW-1:0] StepSAdv   = 5'd5;
  localparam logic [StepW-1:0] StepHit    = 5'd6;
  localparam logic [StepW-1:0] StepBRead  = 5'd7;
  localparam logic [StepW-1:0] StepBWrite = 5'd8;
  localparam logic [StepW-1:0] StepFlip   = 5'd9;
  localparam logic [StepW-1:0] StepNoHit  = 5'd10;
  localparam logic [StepW-1:0] StepESet   = 5'd11;
  localparam logic [StepW-1:0] StepERead  = 5'd12;
  localparam logic [StepW-1:0] StepEWait  = 5'd13;
  localparam logic [StepW-1:0] StepEOut   = 5'd14;
  localparam logic [StepW-1:0] StepZWait  = 5'd15;
  localparam logic [StepW-1:0] StepZOut   = 5'd16;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] jump;
    logic [StepW-1:0] next;
  } ucode_t;

  typedef struct packed {
    logic merge_req;
    logic cor_empty;
    logic vis_empty;
    logic match;
    logic search_done;
    logic k_last;
  } flags_t;

  // The program: the step jumps to jump when its condition holds, else to next.
  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t w;
    unique case (step)
      StepIdle:   w = '{OpAccept,  CondMerge,      StepInit,   StepIdle};
      StepInit:   w = '{OpInit,    CondCorEmpty,   StepZWait,  StepVChk};
      StepVChk:   w = '{OpNone,    CondVisEmpty,   StepNoHit,  StepSRead};
      StepSRead:  w = '{OpSRead,   CondAlways,     StepSCmp,   StepSCmp};
      StepSCmp:   w = '{OpNone,    CondMatch,      StepHit,    StepSAdv};
      StepSAdv:   w = '{OpAdvance, CondSearchDone, StepNoHit,  StepSRead};
      StepHit:    w = '{OpHitSet,  CondAlways,     StepBRead,  StepBRead};
      StepBRead:  w = '{OpBRead,   CondAlways,     StepBWrite, StepBWrite};
      StepBWrite: w = '{OpBWrite,  CondKLast,      StepFlip,   StepBRead};
      StepFlip:   w = '{OpFlip,    CondAlways,     StepESet,   StepESet};
      StepNoHit:  w = '{OpNoHit,   CondAlways,     StepESet,   StepESet};
      StepESet:   w = '{OpESet,    CondAlways,     StepERead,  StepERead};
      StepERead:  w = '{OpERead,   CondAlways,     StepEWait,  StepEWait};
      StepEWait:  w = '{OpNone,    CondOutFree,    StepEOut,   StepEWait};
      StepEOut:   w = '{OpEmit,    CondKLast,      StepIdle,   StepERead};
      StepZWait:  w = '{OpNone,    CondOutFree,    StepZOut,   StepZWait};
      StepZOut:   w = '{OpZEmit,   CondAlways,     StepIdle,   StepIdle};
      default:    w = '{OpNone,    CondAlways,     StepIdle,   StepIdle};
    endcase
    return w;
  endfunction

endpackage

FILE: design/pcm_seq.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
`timescale 1ns / 1ps

module pcm_seq import pcm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  input  logic   out_free_i,
  output ucode_t ctrl_o
);

  logic [StepW-1:0] step_q, step_d;
  ucode_t           word;
  logic             taken;

  assign word   = ucode_rom(step_q);
  assign ctrl_o = word;

  always_comb begin
    unique case (word.cond)
      CondAlways:     taken = 1'b1;
      CondMerge:      taken = flags_i.merge_req;
      CondCorEmpty:   taken = flags_i.cor_empty;
      CondVisEmpty:   taken = flags_i.vis_empty;
      CondMatch:      taken = flags_i.match;
      CondSearchDone: taken = flags_i.search_done;
      CondKLast:      taken = flags_i.k_last;
      CondOutFree:    taken = out_free_i;
      default:        taken = 1'b0;
    endcase
  end

  assign step_d = taken ? word.jump : word.next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: design/pcm_dp.sv
// Datapath: corridor and visited memories, counters, index registers and result assembly.
`timescale 1ns / 1ps

module pcm_dp import pcm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ucode_t ctrl_i,
  input  logic   in_valid_i,
  input  in_t    in_data_i,
  output flags_t flags_o,
  output logic   emit_o,
  output out_t   emit_data_o
);

  // Two banks: a merge that finds a match builds the new corridor in the bank not in use, then flips.
  logic [IdW-1:0] cor_mem [2*CorridorDepth];
  logic [IdW-1:0] vis_mem [VisitedDepth];

  logic               bank_q;
  logic [CorCntW-1:0] ccnt_q;
  logic [VisCntW-1:0] vcnt_q;
  logic               ovf_q;

  logic [CorAddrW-1:0] i_q;
  logic [VisAddrW-1:0] j_q;
  logic [CorAddrW-1:0] k_q;
  logic [CorCntW-1:0]  len_q;
  logic [VisCntW-1:0]  req_q;
  logic [StatusW-1:0]  status_q;
  logic                sel_q;
  logic [IdW-1:0]      cor_rd_q;
  logic [IdW-1:0]      vis_rd_q;

  logic                accept;
  logic                cor_room, vis_room;
  logic                cor_we, vis_we, cor_re, vis_re;
  logic [CorAddrW:0]   cor_waddr, cor_raddr;
  logic [IdW-1:0]      cor_wdata;
  logic                j_last, k_last;
  logic [VisCntW-1:0]  req_new;
  logic [CorCntW-1:0]  tail_new;
  logic [SumW-1:0]     sum_new;
  logic [CorCntW-1:0]  len_new;

  assign accept   = (ctrl_i.op == OpAccept) && in_valid_i;
  assign cor_room = ccnt_q < CorCntW'(CorridorDepth);
  assign vis_room = vcnt_q < VisCntW'(VisitedDepth);

  assign j_last = (VisCntW'(j_q) + VisCntW'(1)) == vcnt_q;
  assign k_last = (CorCntW'(k_q) + CorCntW'(1)) == len_q;

  // Length of the merged corridor: visited tail plus corridor tail, clipped to the depth.
  assign req_new  = vcnt_q - VisCntW'(j_q);
  assign tail_new = ccnt_q - CorCntW'(i_q) - CorCntW'(1);
  assign sum_new  = SumW'(req_new) + SumW'(tail_new);
  assign len_new  = (sum_new > SumW'(CorridorDepth)) ? CorCntW'(CorridorDepth)
                                                     : CorCntW'(sum_new);

  always_comb begin
    cor_we    = 1'b0;
    cor_waddr = {bank_q, ccnt_q[CorAddrW-1:0]};
    cor_wdata = in_data_i.poly_id;
    if (accept && (in_data_i.command == CmdCorAppend) && cor_room) begin
      cor_we = 1'b1;
    end else if (ctrl_i.op == OpBWrite) begin
      cor_we    = 1'b1;
      cor_waddr = {~bank_q, k_q};
      cor_wdata = sel_q ? vis_rd_q : cor_rd_q;
    end
  end

  assign vis_we = accept && (in_data_i.command == CmdVisAppend) && vis_room;

  assign cor_re    = (ctrl_i.op == OpSRead) || (ctrl_i.op == OpBRead) ||
                     (ctrl_i.op == OpERead);
  assign vis_re    = (ctrl_i.op == OpSRead) || (ctrl_i.op == OpBRead);
  assign cor_raddr = (ctrl_i.op == OpERead) ? {bank_q, k_q} : {bank_q, i_q};

  always_ff @(posedge clk_i) begin
    if (cor_we) begin
      cor_mem[cor_waddr] <= cor_wdata;
    end
    if (cor_re) begin
      cor_rd_q <= cor_mem[cor_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vcnt_q[VisAddrW-1:0]] <= in_data_i.poly_id;
    end
    if (vis_re) begin
      vis_rd_q <= vis_mem[j_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
      ccnt_q <= '0;
      vcnt_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      if (accept) begin
        case (in_data_i.command)
          CmdCorAppend: begin
            if (cor_room) begin
              ccnt_q <= ccnt_q + CorCntW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
          CmdVisAppend: begin
            if (vis_room) begin
              vcnt_q <= vcnt_q + VisCntW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
          CmdClear: begin
            ccnt_q <= '0;
            vcnt_q <= '0;
            ovf_q  <= 1'b0;
          end
          default: ;
        endcase
      end
      if (ctrl_i.op == OpFlip) begin
        bank_q <= ~bank_q;
        ccnt_q <= len_q;
      end
      if ((ctrl_i.op == OpESet) || (ctrl_i.op == OpZEmit)) begin
        vcnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OpInit: begin
        i_q <= CorAddrW'(ccnt_q - CorCntW'(1));
        j_q <= '0;
      end
      OpAdvance: begin
        if (j_last) begin
          j_q <= '0;
          i_q <= i_q - CorAddrW'(1);
        end else begin
          j_q <= j_q + VisAddrW'(1);
        end
      end
      OpHitSet: begin
        req_q    <= req_new;
        len_q    <= len_new;
        status_q <= StMerged;
        j_q      <= VisAddrW'(vcnt_q - VisCntW'(1));
        i_q      <= i_q + CorAddrW'(1);
        k_q      <= '0;
      end
      OpBRead: begin
        sel_q <= CorCntW'(k_q) < CorCntW'(req_q);
      end
      OpBWrite: begin
        if (sel_q) begin
          j_q <= j_q - VisAddrW'(1);
        end else begin
          i_q <= i_q + CorAddrW'(1);
        end
        k_q <= k_q + CorAddrW'(1);
      end
      OpNoHit: begin
        status_q <= StNoHit;
        len_q    <= ccnt_q;
      end
      OpESet: begin
        k_q <= '0;
      end
      OpEmit: begin
        k_q <= k_q + CorAddrW'(1);
      end
      default: ;
    endcase
  end

  assign flags_o.merge_req   = in_valid_i && (in_data_i.command == CmdMerge);
  assign flags_o.cor_empty   = (ccnt_q == '0);
  assign flags_o.vis_empty   = (vcnt_q == '0);
  assign flags_o.match       = (cor_rd_q == vis_rd_q);
  assign flags_o.search_done = j_last && (i_q == '0);
  assign flags_o.k_last      = k_last;

  assign emit_o = (ctrl_i.op == OpEmit) || (ctrl_i.op == OpZEmit);

  always_comb begin
    if (ctrl_i.op == OpZEmit) begin
      emit_data_o.poly_id_res = '0;
      emit_data_o.position    = '0;
      emit_data_o.last        = 1'b1;
      emit_data_o.new_length  = '0;
      emit_data_o.status      = StEmpty;
    end else begin
      emit_data_o.poly_id_res = cor_rd_q;
      emit_data_o.position    = PosW'(k_q);
      emit_data_o.last        = k_last;
      emit_data_o.new_length  = LenW'(len_q);
      emit_data_o.status      = status_q;
    end
    emit_data_o.overflow = ovf_q;
  end

endmodule

FILE: design/path_corridor_merge_core.sv
// Top level of the corridor merge block: sequencer, datapath and output word register.
`timescale 1ns / 1ps

// Commands are taken one word at a time. Corridor append, visited append and
// clear complete as they are accepted. A merge runs the setup steps Init and
// VChk, then the search, which reads, compares and, on a mismatch, advances for
// each corridor/visited pair. The corridor is walked from its end and the
// visited list from its start for each corridor entry. When a match is found,
// the rebuild starts with Hit, reads and writes each entry of the rebuilt
// corridor and then switches banks. A search without a match, or an empty
// visited list, ends with the NoHit step. Emission starts with ESet, then reads
// each result and waits while out_stall_i holds the output word before giving
// it. An empty corridor skips the search: after Init its single result waits
// for a free output word. The steps follow from the single read port of the
// corridor memory and the one datapath operation per microcode step. During a
// merge in_stall_o stays high.
module path_corridor_merge_core import pcm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  ucode_t ctrl;
  flags_t flags;
  logic   emit;
  out_t   emit_data;
  logic   out_valid_q;
  out_t   out_data_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  pcm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flags_i    (flags),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  pcm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .flags_o     (flags),
    .emit_o      (emit),
    .emit_data_o (emit_data)
  );

  assign in_stall_o = (ctrl.op != OpAccept);

  // The sequencer only emits after seeing the output register free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: design/pcm_checker.sv
// Port-level checks of the corridor merge block and their binding to the top level.
`timescale 1ns / 1ps

module pcm_checker import pcm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // An accepted merge command keeps the input side stalled the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.command == CmdMerge) |=> in_stall_o)
    else $error("input taken right after a merge command");

  // The input side stays stalled after a result word that is not the last of its run is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=> in_stall_o)
    else $error("input taken in the middle of a merge run");

  // Position, last and length agree on every nonempty result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StEmpty) |->
      ((LenW'(out_data_o.position) + LenW'(1)) <= out_data_o.new_length) &&
      (out_data_o.last == ((LenW'(out_data_o.position) + LenW'(1)) ==
                           out_data_o.new_length)))
    else $error("position, last and new_length disagree");

  // An empty-corridor result is a single zero word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StEmpty) |->
      out_data_o.last && (out_data_o.new_length == '0) &&
      (out_data_o.position == '0) && (out_data_o.poly_id_res == '0))
    else $error("malformed empty-corridor result");

endmodule

bind path_corridor_merge_core pcm_checker u_pcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: sim/tb_top.sv
// Self-checking testbench for the corridor merge block: directed table, random sequences.
`timescale 1ns / 1ps

module tb_top;
  import pcm_pkg::*;

  localparam int unsigned RandItems = 300;
  localparam int unsigned DirRows   = 22;

  typedef struct packed {
    in_t  word;
    logic typed;
    out_t result;
  } dir_row_t;

  localparam out_t EmptyRun = '{32'h0, 6'd0, 1'b1, 7'd0, StEmpty, 1'b0};

  // Typed results are given only where the answer is obvious; the rest come from the predictor.
  localparam dir_row_t DirTable [DirRows] = '{
    '{'{CmdMerge,     32'h0000_0000}, 1'b1, EmptyRun},
    '{'{CmdCorAppend, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{CmdCorAppend, 32'h0000_0000}, 1'b0, '0},
    '{'{CmdCorAppend, 32'h8000_0001}, 1'b0, '0},
    '{'{CmdMerge,     32'h0000_0000}, 1'b0, '0},
    '{'{CmdVisAppend, 32'h1234_5678}, 1'b0, '0},
    '{'{CmdMerge,     32'hFFFF_FFFF}, 1'b0, '0},
    '{'{CmdVisAppend, 32'h0000_0000}, 1'b0, '0},
    '{'{CmdVisAppend, 32'hA5A5_5A5A}, 1'b0, '0},
    '{'{CmdVisAppend, 32'h0000_0000}, 1'b0, '0},
    '{'{CmdMerge,     32'h0000_0000}, 1'b0, '0},
    '{'{CmdClear,     32'h0000_0000}, 1'b0, '0},
    '{'{CmdMerge,     32'h0000_0000}, 1'b1, EmptyRun},
    '{'{CmdCorAppend, 32'h0000_0007}, 1'b0, '0},
    '{'{CmdVisAppend, 32'h0000_0007}, 1'b0, '0},
    '{'{CmdMerge,     32'h0000_0000}, 1'b1, '{32'h7, 6'd0, 1'b1, 7'd1, StMerged, 1'b0}},
    '{'{CmdClear,     32'hFFFF_FFFF}, 1'b0, '0},
    '{'{CmdMerge,     32'h5A5A_5A5A}, 1'b1, EmptyRun},
    '{'{CmdVisAppend, 32'h0000_0005}, 1'b0, '0},
    '{'{CmdMerge,     32'h0000_0000}, 1'b1, EmptyRun},
    '{'{CmdCorAppend, 32'h0000_0005}, 1'b0, '0},
    '{'{CmdMerge,     32'h0000_0000}, 1'b1, '{32'h5, 6'd0, 1'b1, 7'd1, StNoHit, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  path_corridor_merge_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #2 clk = ~clk;

  // Predictor state.
  logic [IdW-1:0] cor_mem [CorridorDepth];
  logic [IdW-1:0] vis_mem [VisitedDepth];
  int unsigned    cor_len = 0;
  int unsigned    vis_len = 0;
  logic           ovf_seen = 1'b0;

  out_t fresh_entries[$];
  out_t expected_entries[$];

  int unsigned err_cnt = 0;
  int unsigned n_sent = 0;
  int unsigned burst_left = 0;
  int unsigned stall_run = 0;
  int unsigned stall_mode = 0;

  function automatic out_t make_entry(logic [IdW-1:0] id, int unsigned pos, int unsigned len,
                                     logic [StatusW-1:0] st);
    out_t e;
    e.poly_id_res = id;
    e.position    = PosW'(pos);
    e.last        = (pos + 1 == len);
    e.new_length  = LenW'(len);
    e.status      = st;
    e.overflow    = ovf_seen;
    return e;
  endfunction

  // Applies one command to the predictor and leaves the corridor it emits in fresh_entries.
  function automatic void predict_corridor(in_t w);
    logic [IdW-1:0]     merged [CorridorDepth];
    logic               hit;
    logic [StatusW-1:0] st;
    int unsigned        hit_cor, hit_vis, req, tail;
    fresh_entries.delete();
    hit = 1'b0;
    hit_cor = 0;
    hit_vis = 0;
    case (w.command)
      CmdCorAppend: begin
        if (cor_len < CorridorDepth) begin
          cor_mem[cor_len] = w.poly_id;
          cor_len++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      CmdVisAppend: begin
        if (vis_len < VisitedDepth) begin
          vis_mem[vis_len] = w.poly_id;
          vis_len++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      CmdMerge: begin
        if (cor_len == 0) begin
          vis_len = 0;
          fresh_entries = {fresh_entries, make_entry('0, 0, 0, StEmpty)};
          fresh_entries[0].last = 1'b1;
        end else begin
          st = StNoHit;
          // Corridor walked from its end; visited list from its start.
          for (int i = int'(cor_len) - 1; i >= 0 && !hit; i--) begin
            for (int j = 0; j < int'(vis_len) && !hit; j++) begin
              if (cor_mem[i] == vis_mem[j]) begin
                hit = 1'b1;
                hit_cor = i;
                hit_vis = j;
              end
            end
          end
          if (hit) begin
            req  = vis_len - hit_vis;
            tail = cor_len - hit_cor - 1;
            if (req + tail > CorridorDepth) tail = CorridorDepth - req;
            for (int k = 0; k < int'(req); k++) merged[k] = vis_mem[vis_len - 1 - k];
            for (int k = 0; k < int'(tail); k++) merged[req + k] = cor_mem[hit_cor + 1 + k];
            cor_len = req + tail;
            for (int k = 0; k < int'(cor_len); k++) cor_mem[k] = merged[k];
            st = StMerged;
          end
          vis_len = 0;
          for (int k = 0; k < int'(cor_len); k++)
            fresh_entries = {fresh_entries, make_entry(cor_mem[k], k, cor_len, st)};
        end
      end
      default: begin
        cor_len  = 0;
        vis_len  = 0;
        ovf_seen = 1'b0;
      end
    endcase
  endfunction

  function automatic in_t make_word(cmd_e c, logic [IdW-1:0] id);
    in_t w;
    w.command = c;
    w.poly_id = id;
    return w;
  endfunction

  // Sends one word in bursts with random gaps, then queues the corridor it produces.
  task automatic send_word(input in_t w, input logic typed, input out_t typed_res);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 7)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    n_sent++;
    predict_corridor(w);
    if (typed) begin
      expected_entries = {expected_entries, typed_res};
    end else begin
      expected_entries = {expected_entries, fresh_entries};
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string name, input longint unsigned want,
                              input longint unsigned got);
    err_cnt++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  // Receiver: stall mode changes now and then, from never stalling to mostly stalled.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(10, 150);
    end
    stall_run--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  out_t want_word;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_entries.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
      end else begin
        want_word = expected_entries.pop_front();
        if (out_data.poly_id_res != want_word.poly_id_res)
          report_field("poly_id_res", want_word.poly_id_res, out_data.poly_id_res);
        if (out_data.position != want_word.position)
          report_field("position", want_word.position, out_data.position);
        if (out_data.last != want_word.last)
          report_field("last", want_word.last, out_data.last);
        if (out_data.new_length != want_word.new_length)
          report_field("new_length", want_word.new_length, out_data.new_length);
        if (out_data.status != want_word.status)
          report_field("status", want_word.status, out_data.status);
        if (out_data.overflow != want_word.overflow)
          report_field("overflow", want_word.overflow, out_data.overflow);
      end
    end
  end

  initial begin
    #30ms;
    $display("[path_corridor_merge_core] ERROR");
    $finish;
  end

  initial begin
    logic [IdW-1:0] pool [8];
    int unsigned    ncor, nvis;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < int'(DirRows); r++)
      send_word(DirTable[r].word, DirTable[r].typed, DirTable[r].result);
    wait_drained();

    // Mostly well-formed sequences: fill both lists from a shared id pool, then merge.
    while (n_sent < DirRows + RandItems) begin
      if ($urandom_range(0, 99) < 80) begin
        foreach (pool[p]) pool[p] = $urandom();
        if ($urandom_range(0, 1) == 1) send_word(make_word(CmdClear, $urandom()), 1'b0, '0);
        ncor = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 10);
        nvis = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 8);
        repeat (ncor)
          send_word(make_word(CmdCorAppend, ($urandom_range(0, 4) != 0) ?
                              pool[$urandom_range(0, 7)] : $urandom()), 1'b0, '0);
        repeat (nvis)
          send_word(make_word(CmdVisAppend, ($urandom_range(0, 9) < 7) ?
                              pool[$urandom_range(0, 7)] : $urandom()), 1'b0, '0);
        send_word(make_word(CmdMerge, $urandom()), 1'b0, '0);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(0, 4))
            send_word(make_word(CmdVisAppend, pool[$urandom_range(0, 7)]), 1'b0, '0);
          send_word(make_word(CmdMerge, $urandom()), 1'b0, '0);
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_word(make_word(cmd_e'($urandom_range(0, 3)), $urandom()), 1'b0, '0);
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[path_corridor_merge_core] OK");
    end else begin
      $display("[path_corridor_merge_core] ERROR");
    end
    $finish;
  end

endmodule
